### hdl/shc_pkg.sv
package shc_pkg;

   localparam int DEF_MAX_BODIES = 256;
   localparam int DEF_BUCKETS    = 4096;
   localparam int DEF_CELL_SHIFT = 7;
   localparam int DEF_MAX_HITS   = 64;

   // hit counter holds up to 127, enough for DEF_MAX_HITS
   localparam int HIT_W = 7;

   localparam logic [15:0] HASH_X_LO = 16'(32'd73856093);
   localparam logic [15:0] HASH_Y_LO = 16'(32'd19349663);

   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_UPDATE   = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_NONE     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_REGISTERED = 2'd0,
      KIND_FULL       = 2'd1,
      KIND_HIT        = 2'd2,
      KIND_EMPTY      = 2'd3
   } kind_type;

   typedef struct packed {
      logic               active;
      logic [7:0]         mask;
      logic [7:0]         layer;
      logic [15:0]        owner;
      logic [14:0]        radius;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } body_type;

   localparam int BODY_W = $bits(body_type);

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  first_body;
      logic [7:0]  second_body;
      logic [15:0] first_owner;
      logic [15:0] second_owner;
      logic        last;
   } result_type;

   // low bits of the prime hash; only the low 16 product bits ever matter
   function automatic logic [15:0] cell_hash(logic [15:0] cx, logic [15:0] cy);
      logic [31:0] px;
      logic [31:0] py;
      px = {16'd0, cx} * {16'd0, HASH_X_LO};
      py = {16'd0, cy} * {16'd0, HASH_Y_LO};
      return px[15:0] ^ py[15:0];
   endfunction

endpackage

### hdl/spatial_hash_circle_collision.sv
// channel | dir | tdata (low bit up)                                 | tuser   | tlast
// req     | in  | owner_tag layer_bits target_mask pos_x pos_y       | command | -
//         |     | radius active                                      |         |
// rsp     | out | first_body second_body first_owner second_owner    | kind    | last
// register: states REG_RD, REG_WR, then EMIT for the output handoff; a full store goes straight to EMIT
// update: BODY, BLOAD per body; CELL, HEAD, CHAIN per cell visited; OLOAD, TEST, CHAIN
//   per chain entry; then DONE; the body memory read port is taken one access at a time
// clear and reset: a clearing pass over the whole bucket memory, no item taken
// a stalled rsp channel holds the sweep only when a second hit has to be handed over
module spatial_hash_circle_collision #(
   parameter int MAX_BODIES = shc_pkg::DEF_MAX_BODIES,
   parameter int BUCKETS    = shc_pkg::DEF_BUCKETS,
   parameter int CELL_SHIFT = shc_pkg::DEF_CELL_SHIFT,
   parameter int MAX_HITS   = shc_pkg::DEF_MAX_HITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // owner_tag, layer_bits, target_mask, pos_x, pos_y, radius, active, zero fill
   input  logic [87:0] req_tdata,
   // command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // first_body, second_body, first_owner, second_owner
   output logic [47:0] rsp_tdata,
   // kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import shc_pkg::*;

   localparam int IW = $clog2(MAX_BODIES);
   localparam int CW = IW + 1;
   localparam int BW = $clog2(BUCKETS);
   localparam logic [CW-1:0] NO_BODY = CW'(MAX_BODIES);
   localparam int RW = BODY_W + CW;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_REG_RD = 13'b0000000000010,
      S_REG_WR = 13'b0000000000100,
      S_EMIT   = 13'b0000000001000,
      S_BODY   = 13'b0000000010000,
      S_BLOAD  = 13'b0000000100000,
      S_CELL   = 13'b0000001000000,
      S_HEAD   = 13'b0000010000000,
      S_CHAIN  = 13'b0000100000000,
      S_OLOAD  = 13'b0001000000000,
      S_TEST   = 13'b0010000000000,
      S_DONE   = 13'b0100000000000,
      S_CLR    = 13'b1000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [BW-1:0]      clr_ff, clr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [14:0]        largest_ff, largest_in;
   logic signed [15:0] minx_ff, minx_in, maxx_ff, maxx_in;
   logic signed [15:0] miny_ff, miny_in, maxy_ff, maxy_in;
   body_type           new_ff, new_in;
   body_type           a_ff, a_in;
   logic [CW-1:0]      i_ff, i_in, o_ff, o_in, next_ff, next_in;
   logic signed [15:0] x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [15:0] gx_ff, gx_in, gy_ff, gy_in;
   logic               cond_ff, cond_in;
   logic [15:0]        bown_ff, bown_in;
   logic [HIT_W-1:0]   hits_ff, hits_in;
   result_type         pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   body_type           req_body;
   logic [15:0]        req_r;
   logic               accept, can_load, out_load;
   result_type         out_data;

   logic               body_we;
   logic [IW-1:0]      body_waddr, body_raddr;
   logic [RW-1:0]      body_wdata, body_rdata;
   logic               head_we;
   logic [BW-1:0]      head_waddr, head_raddr;
   logic [CW-1:0]      head_wdata, head_rdata;

   body_type           rb;
   logic [CW-1:0]      rb_next;
   logic signed [15:0] rb_cx, rb_cy, new_cx, new_cy;
   logic [15:0]        hash_new, hash_grid;
   logic [15:0]        rsum, span;
   logic signed [17:0] x0w, x1w, y0w, y1w;
   logic               pair_hit, hit_now;

   assign req_r = req_tdata[79:64];
   always_comb begin
      req_body.owner  = req_tdata[15:0];
      req_body.layer  = req_tdata[23:16];
      req_body.mask   = req_tdata[31:24];
      req_body.x      = req_tdata[47:32];
      req_body.y      = req_tdata[63:48];
      req_body.radius = req_r[15] ? 15'd0 : req_r[14:0];
      req_body.active = req_tdata[80];
   end

   assign rb      = body_type'(body_rdata[BODY_W-1:0]);
   assign rb_next = body_rdata[BODY_W +: CW];
   assign rb_cx   = rb.x >>> CELL_SHIFT;
   assign rb_cy   = rb.y >>> CELL_SHIFT;
   assign new_cx  = new_ff.x >>> CELL_SHIFT;
   assign new_cy  = new_ff.y >>> CELL_SHIFT;
   assign hash_new  = cell_hash(new_cx, new_cy);
   assign hash_grid = cell_hash(gx_ff, gy_ff);

   // search window around the body's cell, clipped to the box of occupied cells
   assign rsum = {1'b0, rb.radius} + {1'b0, largest_ff};
   assign span = (rsum >> CELL_SHIFT) + 16'd1;
   assign x0w  = 18'(rb_cx) - {2'b00, span};
   assign x1w  = 18'(rb_cx) + {2'b00, span};
   assign y0w  = 18'(rb_cy) - {2'b00, span};
   assign y1w  = 18'(rb_cy) + {2'b00, span};

   assign accept   = req_tvalid && req_tready;
   assign can_load = !out_valid_ff || rsp_tready;
   assign hit_now  = cond_ff && pair_hit;

   shc_ram #(.WIDTH(RW), .DEPTH(MAX_BODIES)) u_body_ram (
      .clock (clock),
      .we    (body_we),
      .waddr (body_waddr),
      .wdata (body_wdata),
      .raddr (body_raddr),
      .rdata (body_rdata)
   );

   shc_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .waddr (head_waddr),
      .wdata (head_wdata),
      .raddr (head_raddr),
      .rdata (head_rdata)
   );

   shc_pair u_pair (
      .clock (clock),
      .load  (state_ff == S_OLOAD),
      .a     (a_ff),
      .b     (rb),
      .hit   (pair_hit)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      largest_in    = largest_ff;
      minx_in       = minx_ff;
      maxx_in       = maxx_ff;
      miny_in       = miny_ff;
      maxy_in       = maxy_ff;
      new_in        = new_ff;
      a_in          = a_ff;
      i_in          = i_ff;
      o_in          = o_ff;
      next_in       = next_ff;
      x0_in         = x0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      cond_in       = cond_ff;
      bown_in       = bown_ff;
      hits_in       = hits_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_load      = 1'b0;
      out_data      = pend_ff;
      req_tready    = 1'b0;
      body_we       = 1'b0;
      body_waddr    = count_ff[IW-1:0];
      body_wdata    = {head_rdata, new_ff};
      body_raddr    = (state_ff == S_CHAIN) ? o_ff[IW-1:0] : i_ff[IW-1:0];
      head_we       = 1'b0;
      head_waddr    = hash_new[BW-1:0];
      head_wdata    = count_ff;
      head_raddr    = (state_ff == S_REG_RD) ? hash_new[BW-1:0] : hash_grid[BW-1:0];

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               case (command_type'(req_tuser))
                  CMD_REGISTER: begin
                     new_in = req_body;
                     if (count_ff >= NO_BODY) begin
                        pend_in  = '{KIND_FULL, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1};
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_REG_RD;
                     end
                  end
                  CMD_UPDATE: begin
                     i_in          = '0;
                     hits_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_BODY;
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_REG_RD: state_in = S_REG_WR;
         S_REG_WR: begin
            // new body goes to the head of its bucket chain
            body_we  = 1'b1;
            head_we  = 1'b1;
            count_in = count_ff + CW'(1);
            if (new_ff.radius > largest_ff) largest_in = new_ff.radius;
            if (count_ff == '0 || new_cx < minx_ff) minx_in = new_cx;
            if (count_ff == '0 || new_cx > maxx_ff) maxx_in = new_cx;
            if (count_ff == '0 || new_cy < miny_ff) miny_in = new_cy;
            if (count_ff == '0 || new_cy > maxy_ff) maxy_in = new_cy;
            pend_in  = '{KIND_REGISTERED, 8'(count_ff), 8'd0, new_ff.owner, 16'd0, 1'b1};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (can_load) begin
               out_load = 1'b1;
               out_data = pend_ff;
               state_in = S_IDLE;
            end
         end
         S_BODY: begin
            if (i_ff < count_ff && hits_ff < HIT_W'(MAX_HITS)) state_in = S_BLOAD;
            else state_in = S_DONE;
         end
         S_BLOAD: begin
            if (!rb.active || rb.layer == 8'd0) begin
               i_in     = i_ff + CW'(1);
               state_in = S_BODY;
            end else begin
               a_in     = rb;
               x0_in    = (x0w < 18'(minx_ff)) ? minx_ff : x0w[15:0];
               x1_in    = (x1w > 18'(maxx_ff)) ? maxx_ff : x1w[15:0];
               gy_in    = (y0w < 18'(miny_ff)) ? miny_ff : y0w[15:0];
               y1_in    = (y1w > 18'(maxy_ff)) ? maxy_ff : y1w[15:0];
               gx_in    = (x0w < 18'(minx_ff)) ? minx_ff : x0w[15:0];
               state_in = S_CELL;
            end
         end
         S_CELL: state_in = S_HEAD;
         S_HEAD: begin
            o_in     = head_rdata;
            state_in = S_CHAIN;
         end
         S_CHAIN: begin
            if (hits_ff >= HIT_W'(MAX_HITS)) begin
               state_in = S_DONE;
            end else if (o_ff < count_ff) begin
               state_in = S_OLOAD;
            end else if (gx_ff != x1_ff) begin
               gx_in    = gx_ff + 16'sd1;
               state_in = S_CELL;
            end else if (gy_ff != y1_ff) begin
               gy_in    = gy_ff + 16'sd1;
               gx_in    = x0_ff;
               state_in = S_CELL;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_BODY;
            end
         end
         S_OLOAD: begin
            // chain entries of other cells share the bucket and are skipped
            cond_in  = (rb_cx == gx_ff) && (rb_cy == gy_ff) && (o_ff > i_ff);
            next_in  = rb_next;
            bown_in  = rb.owner;
            state_in = S_TEST;
         end
         S_TEST: begin
            // one hit is held back until it is known whether it is the last
            if (!(hit_now && pend_valid_ff && !can_load)) begin
               if (hit_now) begin
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     out_data = pend_ff;
                  end
                  pend_in = '{KIND_HIT, 8'(i_ff), 8'(o_ff), a_ff.owner, bown_ff, 1'b0};
                  pend_valid_in = 1'b1;
                  hits_in       = hits_ff + HIT_W'(1);
               end
               o_in     = next_ff;
               state_in = S_CHAIN;
            end
         end
         S_DONE: begin
            if (can_load) begin
               out_load = 1'b1;
               if (pend_valid_ff) begin
                  out_data      = pend_ff;
                  out_data.last = 1'b1;
               end else begin
                  out_data = '{KIND_EMPTY, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1};
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_CLR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NO_BODY;
            clr_in     = clr_ff + BW'(1);
            count_in   = '0;
            largest_in = '0;
            if (&clr_ff) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      out_in       = out_load ? out_data : out_ff;
      out_valid_in = out_load || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ff        <= '0;
         count_ff      <= '0;
         largest_ff    <= '0;
         hits_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         largest_ff    <= largest_in;
         hits_ff       <= hits_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      minx_ff <= minx_in;
      maxx_ff <= maxx_in;
      miny_ff <= miny_in;
      maxy_ff <= maxy_in;
      new_ff  <= new_in;
      a_ff    <= a_in;
      i_ff    <= i_in;
      o_ff    <= o_in;
      next_ff <= next_in;
      x0_ff   <= x0_in;
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      cond_ff <= cond_in;
      bown_ff <= bown_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {out_ff.second_owner, out_ff.first_owner,
                        out_ff.second_body, out_ff.first_body};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NO_BODY) else $error("body count past store size");
   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= HIT_W'(MAX_HITS)) else $error("hit count past limit");
   a_store_room: assert property (@(posedge clock) disable iff (reset)
      body_we |-> count_ff < NO_BODY) else $error("body written into full store");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_HIT |-> rsp_tlast)
      else $error("single result item without last");
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HIT |-> rsp_tdata[7:0] != rsp_tdata[15:8])
      else $error("hit pair names one body twice");
`endif

endmodule

### hdl/shc_ram.sv
module shc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hdl/shc_pair.sv
module shc_pair (
   input  logic              clock,
   input  logic              load,
   input  shc_pkg::body_type a,
   input  shc_pkg::body_type b,
   output logic              hit
);
   import shc_pkg::*;

   logic [33:0] dx2_ff, dx2_in;
   logic [33:0] dy2_ff, dy2_in;
   logic [31:0] rs2_ff, rs2_in;
   logic        layer_ok_ff, layer_ok_in;
   logic signed [16:0] dx, dy;
   logic [15:0] rs;
   logic [34:0] dist2;

   always_comb begin
      dx = 17'(a.x) - 17'(b.x);
      dy = 17'(a.y) - 17'(b.y);
      rs = {1'b0, a.radius} + {1'b0, b.radius};
      dx2_in = 34'(dx * dx);
      dy2_in = 34'(dy * dy);
      rs2_in = rs * rs;
      layer_ok_in = b.active && (b.layer != 8'd0) &&
                    (((a.mask & b.layer) != 8'd0) || ((b.mask & a.layer) != 8'd0));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dx2_ff      <= dx2_in;
         dy2_ff      <= dy2_in;
         rs2_ff      <= rs2_in;
         layer_ok_ff <= layer_ok_in;
      end
   end

   assign dist2 = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign hit   = layer_ok_ff && (dist2 <= {3'd0, rs2_ff});

endmodule

### verif/tb_spatial_hash_circle_collision.sv
`timescale 1ns / 100ps

module tb_spatial_hash_circle_collision;
   import shc_pkg::*;

   class collision_scoreboard;
      int          body_x[256];
      int          body_y[256];
      int          body_rad[256];
      int          cell_x[256];
      int          cell_y[256];
      int          chain_next[256];
      int          bucket_first[4096];
      bit [15:0]   owner[256];
      bit [7:0]    layer[256];
      bit [7:0]    reach_mask[256];
      bit          active[256];
      int          largest;
      int          count;
      int          errors;
      result_type  pending[$];

      function new();
         errors = 0;
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < 4096; i++) bucket_first[i] = 256;
         for (int i = 0; i < 256; i++) begin
            chain_next[i] = 256;
            cell_x[i] = 0;
            cell_y[i] = 0;
         end
         largest = 0;
         count = 0;
      endfunction

      function int bucket_of(int gx, int gy);
         bit [31:0] h;
         h = (32'(gx) * 32'd73856093) ^ (32'(gy) * 32'd19349663);
         return int'(h[11:0]);
      endfunction

      function result_type make(kind_type k, int a, int b, bit [15:0] oa, bit [15:0] ob,
                                bit l);
         result_type r;
         r.kind = k;
         r.first_body = a[7:0];
         r.second_body = b[7:0];
         r.first_owner = oa;
         r.second_owner = ob;
         r.last = l;
         return r;
      endfunction

      function bit overlaps(int a, int b);
         longint dx;
         longint dy;
         longint rs;
         if (a >= b || !active[b] || layer[b] == 0) return 0;
         if ((reach_mask[a] & layer[b]) == 0 && (reach_mask[b] & layer[a]) == 0) return 0;
         dx = longint'(body_x[a]) - body_x[b];
         dy = longint'(body_y[a]) - body_y[b];
         rs = longint'(body_rad[a]) + body_rad[b];
         return dx * dx + dy * dy <= rs * rs;
      endfunction

      function void sweep();
         int minx, maxx, miny, maxy, s, x0, x1, y0, y1, o, guard, hits;
         hits = 0;
         minx = 0; maxx = -1; miny = 0; maxy = -1;
         for (int i = 0; i < count; i++) begin
            if (i == 0 || cell_x[i] < minx) minx = cell_x[i];
            if (i == 0 || cell_x[i] > maxx) maxx = cell_x[i];
            if (i == 0 || cell_y[i] < miny) miny = cell_y[i];
            if (i == 0 || cell_y[i] > maxy) maxy = cell_y[i];
         end
         for (int i = 0; i < count && hits < 64; i++) begin
            if (!active[i] || layer[i] == 0) continue;
            s = ((body_rad[i] + largest) >>> 7) + 1;
            x0 = (cell_x[i] - s < minx) ? minx : cell_x[i] - s;
            x1 = (cell_x[i] + s > maxx) ? maxx : cell_x[i] + s;
            y0 = (cell_y[i] - s < miny) ? miny : cell_y[i] - s;
            y1 = (cell_y[i] + s > maxy) ? maxy : cell_y[i] + s;
            for (int gy = y0; gy <= y1; gy++) begin
               for (int gx = x0; gx <= x1; gx++) begin
                  o = bucket_first[bucket_of(gx, gy)];
                  guard = 0;
                  while (o < count && guard <= 256) begin
                     if (cell_x[o] == gx && cell_y[o] == gy && hits < 64 && overlaps(i, o))
                     begin
                        pending.push_back(make(KIND_HIT, i, o, owner[i], owner[o], 0));
                        hits++;
                     end
                     o = chain_next[o];
                     guard++;
                  end
               end
            end
         end
         if (hits == 0) pending.push_back(make(KIND_EMPTY, 0, 0, 0, 0, 1));
         else pending[$].last = 1;
      endfunction

      function void note(command_type c, logic [87:0] d);
         int id, b, r;
         case (c)
            CMD_REGISTER: begin
               if (count >= 256) begin
                  pending.push_back(make(KIND_FULL, 0, 0, 0, 0, 1));
               end else begin
                  id = count;
                  owner[id] = d[15:0];
                  layer[id] = d[23:16];
                  reach_mask[id] = d[31:24];
                  body_x[id] = int'($signed(d[47:32]));
                  body_y[id] = int'($signed(d[63:48]));
                  r = int'($signed(d[79:64]));
                  body_rad[id] = (r < 0) ? 0 : r;
                  active[id] = d[80];
                  if (body_rad[id] > largest) largest = body_rad[id];
                  cell_x[id] = body_x[id] >>> 7;
                  cell_y[id] = body_y[id] >>> 7;
                  b = bucket_of(cell_x[id], cell_y[id]);
                  chain_next[id] = bucket_first[b];
                  bucket_first[b] = id;
                  count++;
                  pending.push_back(make(KIND_REGISTERED, id, 0, owner[id], 0, 1));
               end
            end
            CMD_UPDATE: sweep();
            CMD_CLEAR: wipe();
            default: ;
         endcase
      endfunction

      function void report(string name, logic [15:0] want, logic [15:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      endfunction

      function void check(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind) report("kind", want.kind, got.kind);
         if (got.first_body !== want.first_body)
            report("first_body", want.first_body, got.first_body);
         if (got.second_body !== want.second_body)
            report("second_body", want.second_body, got.second_body);
         if (got.first_owner !== want.first_owner)
            report("first_owner", want.first_owner, got.first_owner);
         if (got.second_owner !== want.second_owner)
            report("second_owner", want.second_owner, got.second_owner);
         if (got.last !== want.last) report("last", want.last, got.last);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   collision_scoreboard board = new();
   bit long_hold = 0;
   int hold_left = 0;
   int items = 0;

   always #1 clock = ~clock;

   spatial_hash_circle_collision DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   function int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // called at the falling edge, returns at the falling edge after acceptance
   task send(command_type c, logic [87:0] d);
      req_tvalid <= 1;
      req_tuser <= c;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      board.note(c, d);
      items++;
      @(negedge clock);
   endtask

   task pause(int n);
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   task add_body(bit [15:0] o, bit [7:0] l, bit [7:0] m, logic [15:0] x, logic [15:0] y,
                 logic [15:0] r, bit a);
      send(CMD_REGISTER, {7'd0, a, r, y, x, m, l, o});
   endtask

   task drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   task random_body(int base_x, int base_y, int span);
      int p;
      logic [15:0] r;
      p = $urandom_range(0, 9);
      if (p < 8) r = 16'($urandom_range(0, 120));
      else if (p < 9) r = 16'(-int'($urandom_range(1, 32768)));
      else r = 16'($urandom_range(0, 32767));
      add_body(16'($urandom), ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom),
               8'($urandom), 16'(base_x + $urandom_range(0, span)),
               16'(base_y + $urandom_range(0, span)), r, $urandom_range(0, 6) != 0);
   endtask

   // receiver: random stalls plus one long hold counted here
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            board.check({kind_type'(rsp_tuser), rsp_tdata[7:0], rsp_tdata[15:8],
                         rsp_tdata[31:16], rsp_tdata[47:32], rsp_tlast});
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else if (long_hold) begin
            long_hold = 0;
            hold_left = 3000;
            rsp_tready <= 0;
         end else begin
            hold_left = gap_len();
            rsp_tready <= (hold_left == 0);
            if (hold_left > 0) hold_left--;
         end
      end
   end

   initial begin
      int base_x, base_y, span, p;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // empty store, ignored command
      send(CMD_UPDATE, '0);
      send(CMD_NONE, '1);
      // coordinate and radius extremes, cleared before any sweep
      add_body(16'hffff, 8'hff, 8'hff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
      add_body(16'h0000, 8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000, 0);
      send(CMD_CLEAR, '0);
      // huge radius around the origin, pair across a cell border, skipped bodies
      add_body(16'h1111, 8'h01, 8'h00, 16'h0000, 16'h0000, 16'h7fff, 1);
      add_body(16'h2222, 8'h02, 8'h01, 16'hffff, 16'hffff, 16'h0000, 1);
      add_body(16'h3333, 8'h00, 8'hff, 16'd100, 16'h0000, 16'hfffb, 1);
      add_body(16'h4444, 8'hff, 8'hff, 16'd5, 16'd5, 16'd10, 0);
      add_body(16'h5555, 8'h80, 8'h40, 16'd3, 16'd3, 16'd10, 1);
      send(CMD_UPDATE, '0);
      send(CMD_CLEAR, '0);
      // more overlapping pairs than the hit limit
      for (int i = 0; i < 13; i++) add_body(16'(i), 8'h01, 8'h01, 16'(i), 16'(i), 16'd50, 1);
      send(CMD_UPDATE, '0);
      send(CMD_CLEAR, '0);
      // fill the store, then one more
      for (int i = 0; i < 257; i++)
         add_body(16'(i * 7), (i < 10) ? 8'h01 : 8'h00, 8'h01, 16'(i % 100), 16'(i % 90),
                  16'd20, 1);
      send(CMD_UPDATE, '0);
      send(CMD_CLEAR, '0);
      drain();

      // random mix tops the run up to about 340 items
      base_x = 0; base_y = 0; span = 400;
      while (items < 340) begin
         if (items == 300) long_hold = 1;
         if (items % 60 == 59) drain();
         p = $urandom_range(0, 99);
         if (board.count > 30 || p < 6) begin
            send(CMD_CLEAR, '0);
            span = ($urandom_range(0, 3) == 0) ? 2000 : 400;
            base_x = int'($urandom_range(0, 65535 - span)) - 32768;
            base_y = int'($urandom_range(0, 65535 - span)) - 32768;
         end else if (p < 9) begin
            send(CMD_NONE, 88'($urandom));
         end else if (p < 34) begin
            send(CMD_UPDATE, '0);
         end else begin
            random_body(base_x, base_y, span);
         end
         if (!(items >= 300 && items < 325)) pause(gap_len());
      end
      req_tvalid <= 0;

      while (board.pending.size() != 0 || hold_left > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #50000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
